// ===== sv/huffman_build_and_encode_core_defines.svh =====
// Assertion macros for the static Huffman build-and-encode core.
// Used by the files that carry concurrent checks; no other dependencies.
`ifndef HUFFMAN_BUILD_AND_ENCODE_CORE_DEFINES_SVH
`define HUFFMAN_BUILD_AND_ENCODE_CORE_DEFINES_SVH

// same-cycle implication, reset masks the check
`define HBE_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HBE_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/hbe_pkg.sv =====
// Shared constants, codes and memory request/response types for the Huffman core.
// No dependencies; imported by every module of the block.
package hbe_pkg;

  localparam int SYMBOLS      = 256;
  localparam int SYM_W        = $clog2(SYMBOLS);
  localparam int NODES        = 2 * SYMBOLS - 1;
  localparam int NODE_W       = $clog2(NODES);
  localparam int KIDS_W       = 2 * NODE_W;
  localparam int COUNT_W      = 32;
  localparam int WEIGHT_W     = 32;
  localparam int MAX_CODE_LEN = 48;
  localparam int LEN_W        = 6;
  localparam int INFO_W       = LEN_W + MAX_CODE_LEN;
  localparam int TOTAL_W      = 38;
  localparam int BYTE_W       = 8;
  localparam int PEND_W       = BYTE_W + MAX_CODE_LEN;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [1:0] KIND_COUNT  = 2'd0;
  localparam logic [1:0] KIND_BUILD  = 2'd1;
  localparam logic [1:0] KIND_ENCODE = 2'd2;
  localparam logic [1:0] KIND_FLUSH  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NO_CODE   = 2'd2;
  localparam logic [1:0] ST_NOT_BUILT = 2'd3;

  typedef struct packed {
    logic [SYM_W-1:0]        addr;
    logic                    cnt_we;
    logic [COUNT_W-1:0]      cnt_wd;
    logic                    code_we;
    logic [LEN_W-1:0]        code_len;
    logic [MAX_CODE_LEN-1:0] code_bits;
  } sym_req_t;

  typedef struct packed {
    logic [COUNT_W-1:0]      cnt;
    logic [LEN_W-1:0]        code_len;
    logic [MAX_CODE_LEN-1:0] code_bits;
  } sym_rsp_t;

  typedef struct packed {
    logic [NODE_W-1:0] addr;
    logic              we_data;
    logic              we_kids;
    logic              we_live;
    logic [INFO_W-1:0] data;
    logic [KIDS_W-1:0] kids;
    logic              live;
  } node_req_t;

  typedef struct packed {
    logic [INFO_W-1:0] data;
    logic [KIDS_W-1:0] kids;
    logic              live;
  } node_rsp_t;

  // merge order key: weight, then symbol (internal = 0), then node index
  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [SYM_W-1:0]    sym;
    logic [NODE_W-1:0]   idx;
  } key_t;

endpackage

// ===== sv/hbe_sym_mem.sv =====
// Per-symbol store: histogram counts and code table, one shared address port.
// Read data registered; the core clears entries with a write pass. Uses hbe_pkg.
module hbe_sym_mem (
  input  logic              clk,
  input  hbe_pkg::sym_req_t req,
  output hbe_pkg::sym_rsp_t rsp
);
  import hbe_pkg::*;

  logic [COUNT_W-1:0]      cnt_mem_r  [SYMBOLS];
  logic [INFO_W-1:0]       code_mem_r [SYMBOLS];
  logic [COUNT_W-1:0]      cnt_q_r;
  logic [INFO_W-1:0]       code_q_r;

  always_ff @(posedge clk) begin
    if (req.cnt_we) begin
      cnt_mem_r[req.addr] <= req.cnt_wd;
    end
    if (req.code_we) begin
      code_mem_r[req.addr] <= {req.code_len, req.code_bits};
    end
    cnt_q_r  <= cnt_mem_r[req.addr];
    code_q_r <= code_mem_r[req.addr];
  end

  assign rsp.cnt       = cnt_q_r;
  assign rsp.code_len  = code_q_r[INFO_W-1:MAX_CODE_LEN];
  assign rsp.code_bits = code_q_r[MAX_CODE_LEN-1:0];

endmodule

// ===== sv/hbe_node_mem.sv =====
// Tree node store: weight (later depth and code), child pair and live flag per node.
// One address for read and write, read data registered. Uses hbe_pkg.
module hbe_node_mem (
  input  logic               clk,
  input  hbe_pkg::node_req_t req,
  output hbe_pkg::node_rsp_t rsp
);
  import hbe_pkg::*;

  logic [INFO_W-1:0] data_mem_r [NODES];
  logic [KIDS_W-1:0] kids_mem_r [NODES];
  logic              live_mem_r [NODES];

  always_ff @(posedge clk) begin
    if (req.we_data) begin
      data_mem_r[req.addr] <= req.data;
    end
    if (req.we_kids) begin
      kids_mem_r[req.addr] <= req.kids;
    end
    if (req.we_live) begin
      live_mem_r[req.addr] <= req.live;
    end
    rsp.data <= data_mem_r[req.addr];
    rsp.kids <= kids_mem_r[req.addr];
    rsp.live <= live_mem_r[req.addr];
  end

endmodule

// ===== sv/huffman_build_and_encode_core.sv =====
// Static two-pass Huffman encoder core: histogram, tree build, code packing.
// Depends on hbe_pkg, hbe_sym_mem, hbe_node_mem and the assertion macro header.
//
//  channel | ports                                        | dir
//  --------+----------------------------------------------+-----
//  input   | in_valid in_ready in_kind in_byte            | in
//  result  | out_valid out_ready out_byte out_last_of_run | out
//          | out_status out_total_bits                    |
//
// Steps: count reads, then updates the entry; encode loads the code, then emits each byte,
//   or reports an error; flush emits the padded byte, then a pass clears histogram and code table.
// Build: the histogram sweep, a decision, then per merge the min-two scan of the node store
//   and the two live-flag updates (no live-flag updates after the last merge), then
//   code assignment per internal node, then the result.
// Reset (rst_n low, synchronous) starts the same clearing pass.
// A result waiting in the output register does not block accepting the next word;
//   result-producing states wait for the output register to drain.
`include "huffman_build_and_encode_core_defines.svh"

module huffman_build_and_encode_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_kind,
  input  logic [hbe_pkg::SYM_W-1:0]     in_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hbe_pkg::BYTE_W-1:0]    out_byte,
  output logic                          out_last_of_run,
  output logic [1:0]                    out_status,
  output logic [hbe_pkg::TOTAL_W:0]     out_total_bits
);
  import hbe_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CNT_WR, S_ENC_LD, S_EMIT, S_FLUSH, S_RESULT, S_CLR,
    S_LD_RD, S_LD_WR, S_LD_END, S_SCAN, S_KILL0, S_KILL1, S_T_RD, S_T_W0, S_T_W1
  } state_t;

  sym_req_t  sreq;
  sym_rsp_t  srsp;
  node_req_t nreq;
  node_rsp_t nrsp;

  hbe_sym_mem u_sym (.clk(clk), .req(sreq), .rsp(srsp));
  hbe_node_mem u_node (.clk(clk), .req(nreq), .rsp(nrsp));

  state_t              state_r, state_nxt;
  logic [SYM_W-1:0]    byte_r, byte_nxt;
  logic [6:0]          acc_r, acc_nxt;
  logic [2:0]          fill_r, fill_nxt;
  logic [TOTAL_W-1:0]  total_r, total_nxt;
  logic                tbl_rdy_r, tbl_rdy_nxt;
  logic [1:0]          res_stat_r, res_stat_nxt;
  logic [NODE_W-1:0]   idx_r, idx_nxt;
  logic [NODE_W-1:0]   n_r, n_nxt;
  logic [SYM_W-1:0]    lone_r, lone_nxt;
  logic [NODE_W-1:0]   next_r, next_nxt;
  logic [NODE_W-1:0]   merge_k_r, merge_k_nxt;
  logic [NODE_W-1:0]   root_r, root_nxt;
  key_t                best_key_r, best_key_nxt;
  key_t                sec_key_r, sec_key_nxt;
  logic                best_v_r, best_v_nxt;
  logic                sec_v_r, sec_v_nxt;
  logic                scan_v_r, scan_v_nxt;
  logic [NODE_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic [PEND_W-1:0]   pend_r, pend_nxt;
  logic [LEN_W-1:0]    pend_cnt_r, pend_cnt_nxt;
  logic [NODE_W-1:0]   t_node_r, t_node_nxt;
  logic [LEN_W-1:0]    t_depth_r, t_depth_nxt;
  logic [MAX_CODE_LEN-1:0] t_code_r, t_code_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]   out_byte_r, out_byte_nxt;
  logic                out_last_r, out_last_nxt;
  logic [1:0]          out_stat_r, out_stat_nxt;
  logic [TOTAL_W-1:0]  out_total_r, out_total_nxt;

  logic                out_free;
  logic                scan_done;
  logic                pair_ok;
  logic [BYTE_W-1:0]   a8;
  logic [MAX_CODE_LEN-1:0] code_al;
  logic [PEND_W-1:0]   pend_c;
  logic [LEN_W-1:0]    cnt_c;
  logic [TOTAL_W:0]    tsum;
  logic [LEN_W-1:0]    rem_cnt;
  logic [BYTE_W-1:0]   tail8;
  key_t                x_key;
  logic [WEIGHT_W:0]   wsum;
  logic [WEIGHT_W-1:0] wsat;
  logic [LEN_W-1:0]    par_depth, kid_depth, ch_depth;
  logic [MAX_CODE_LEN-1:0] par_code, ch_code;
  logic [NODE_W-1:0]   ch_node;

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;
  assign out_status      = out_stat_r;
  assign out_total_bits  = {1'b0, out_total_r};

  assign out_free  = !out_valid_r || out_ready;
  assign scan_done = (state_r == S_SCAN) && (idx_r == next_r) && !scan_v_r;
  assign pair_ok   = best_v_r && sec_v_r && (best_key_r.idx != sec_key_r.idx);

  // pending packer bits left-aligned in a byte; zero when nothing pending
  assign a8      = {1'b0, acc_r} << (4'd8 - {1'b0, fill_r});
  assign code_al = srsp.code_bits << (LEN_W'(MAX_CODE_LEN) - srsp.code_len);
  assign pend_c  = {a8, {MAX_CODE_LEN{1'b0}}} | ({code_al, {BYTE_W{1'b0}}} >> fill_r);
  assign cnt_c   = LEN_W'(fill_r) + srsp.code_len;
  assign tsum    = {1'b0, total_r} + (TOTAL_W + 1)'(srsp.code_len);

  // scan candidate key from the word read last cycle
  always_comb begin
    x_key.weight = nrsp.data[WEIGHT_W-1:0];
    x_key.sym    = (scan_idx_r < SYMBOLS) ? scan_idx_r[SYM_W-1:0] : '0;
    x_key.idx    = scan_idx_r;
  end

  assign wsum = {1'b0, best_key_r.weight} + {1'b0, sec_key_r.weight};
  assign wsat = wsum[WEIGHT_W] ? '1 : wsum[WEIGHT_W-1:0];

  // code assignment: parent info comes from the node store, root is depth 0
  always_comb begin
    par_depth = (idx_r == root_r) ? '0 : nrsp.data[INFO_W-1:MAX_CODE_LEN];
    par_code  = (idx_r == root_r) ? '0 : nrsp.data[MAX_CODE_LEN-1:0];
    kid_depth = (par_depth == '1) ? par_depth : par_depth + 1'b1;
    if (state_r == S_T_W1) begin
      ch_node  = t_node_r;
      ch_depth = t_depth_r;
      ch_code  = t_code_r;
    end else begin
      ch_node  = nrsp.kids[KIDS_W-1:NODE_W];
      ch_depth = kid_depth;
      ch_code  = {par_code[MAX_CODE_LEN-2:0], 1'b0};
    end
  end

  always_comb begin
    state_nxt     = state_r;
    byte_nxt      = byte_r;
    acc_nxt       = acc_r;
    fill_nxt      = fill_r;
    total_nxt     = total_r;
    tbl_rdy_nxt   = tbl_rdy_r;
    res_stat_nxt  = res_stat_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    lone_nxt      = lone_r;
    next_nxt      = next_r;
    merge_k_nxt   = merge_k_r;
    root_nxt      = root_r;
    best_key_nxt  = best_key_r;
    sec_key_nxt   = sec_key_r;
    best_v_nxt    = best_v_r;
    sec_v_nxt     = sec_v_r;
    scan_v_nxt    = scan_v_r;
    scan_idx_nxt  = scan_idx_r;
    pend_nxt      = pend_r;
    pend_cnt_nxt  = pend_cnt_r;
    t_node_nxt    = t_node_r;
    t_depth_nxt   = t_depth_r;
    t_code_nxt    = t_code_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_stat_nxt  = out_stat_r;
    out_total_nxt = out_total_r;
    rem_cnt       = '0;
    tail8         = '0;
    sreq          = '0;
    sreq.addr     = byte_r;
    nreq          = '0;
    nreq.addr     = idx_r;

    case (state_r)
      S_IDLE: begin
        sreq.addr = in_byte;
        if (in_valid) begin
          byte_nxt = in_byte;
          case (in_kind)
            KIND_COUNT:  state_nxt = S_CNT_WR;
            KIND_BUILD: begin
              tbl_rdy_nxt   = 1'b0;
              n_nxt         = '0;
              idx_nxt       = '0;
              state_nxt     = S_LD_RD;
            end
            KIND_ENCODE: state_nxt = S_ENC_LD;
            default:     state_nxt = S_FLUSH;
          endcase
        end
      end

      S_CNT_WR: begin
        if (srsp.cnt != COUNT_MAX) begin
          sreq.cnt_we = 1'b1;
          sreq.cnt_wd = srsp.cnt + 1'b1;
        end
        state_nxt = S_IDLE;
      end

      S_ENC_LD: begin
        if (!tbl_rdy_r) begin
          res_stat_nxt = ST_NOT_BUILT;
          state_nxt    = S_RESULT;
        end else if (srsp.code_len == '0) begin
          res_stat_nxt = ST_NO_CODE;
          state_nxt    = S_RESULT;
        end else begin
          total_nxt    = tsum[TOTAL_W] ? '1 : tsum[TOTAL_W-1:0];
          pend_nxt     = pend_c;
          pend_cnt_nxt = cnt_c;
          if (cnt_c < LEN_W'(BYTE_W)) begin
            // no byte completes: keep the bits in the packer
            rem_cnt   = cnt_c;
            tail8     = pend_c[PEND_W-1 -: BYTE_W] >> (4'd8 - {1'b0, rem_cnt[2:0]});
            acc_nxt   = tail8[6:0];
            fill_nxt  = rem_cnt[2:0];
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end

      S_EMIT: begin
        if (out_free) begin
          rem_cnt       = pend_cnt_r - LEN_W'(BYTE_W);
          out_valid_nxt = 1'b1;
          out_byte_nxt  = pend_r[PEND_W-1 -: BYTE_W];
          out_last_nxt  = (rem_cnt < LEN_W'(BYTE_W));
          out_stat_nxt  = ST_OK;
          out_total_nxt = total_r;
          pend_nxt      = pend_r << BYTE_W;
          pend_cnt_nxt  = rem_cnt;
          if (rem_cnt < LEN_W'(BYTE_W)) begin
            tail8     = pend_r[PEND_W-BYTE_W-1 -: BYTE_W] >> (4'd8 - {1'b0, rem_cnt[2:0]});
            acc_nxt   = tail8[6:0];
            fill_nxt  = rem_cnt[2:0];
            state_nxt = S_IDLE;
          end
        end
      end

      S_FLUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = a8;
          out_last_nxt  = 1'b1;
          out_stat_nxt  = ST_OK;
          out_total_nxt = total_r;
          tbl_rdy_nxt   = 1'b0;
          acc_nxt       = '0;
          fill_nxt      = '0;
          total_nxt     = '0;
          idx_nxt       = '0;
          state_nxt     = S_CLR;
        end
      end

      S_RESULT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = '0;
          out_last_nxt  = 1'b1;
          out_stat_nxt  = res_stat_r;
          out_total_nxt = total_r;
          state_nxt     = S_IDLE;
        end
      end

      // one entry per cycle: zero count, no code
      S_CLR: begin
        sreq.addr    = idx_r[SYM_W-1:0];
        sreq.cnt_we  = 1'b1;
        sreq.code_we = 1'b1;
        if (idx_r == NODE_W'(SYMBOLS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      // histogram sweep: each nonzero count becomes a live leaf, old codes dropped
      S_LD_RD: begin
        sreq.addr = idx_r[SYM_W-1:0];
        state_nxt = S_LD_WR;
      end

      S_LD_WR: begin
        sreq.addr    = idx_r[SYM_W-1:0];
        sreq.code_we = 1'b1;
        nreq.we_data = 1'b1;
        nreq.data    = INFO_W'(srsp.cnt);
        nreq.we_live = 1'b1;
        nreq.live    = (srsp.cnt != '0);
        if (srsp.cnt != '0) begin
          n_nxt    = n_r + 1'b1;
          lone_nxt = idx_r[SYM_W-1:0];
        end
        if (idx_r == NODE_W'(SYMBOLS - 1)) begin
          state_nxt = S_LD_END;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_LD_RD;
        end
      end

      S_LD_END: begin
        if (n_r == '0) begin
          res_stat_nxt = ST_EMPTY;
          state_nxt    = S_RESULT;
        end else if (n_r == NODE_W'(1)) begin
          // single symbol gets the one-bit code 0
          sreq.addr      = lone_r;
          sreq.code_we   = 1'b1;
          sreq.code_len  = LEN_W'(1);
          sreq.code_bits = '0;
          tbl_rdy_nxt    = 1'b1;
          res_stat_nxt   = ST_OK;
          state_nxt      = S_RESULT;
        end else begin
          next_nxt    = NODE_W'(SYMBOLS);
          merge_k_nxt = '0;
          idx_nxt     = '0;
          best_v_nxt  = 1'b0;
          sec_v_nxt   = 1'b0;
          scan_v_nxt  = 1'b0;
          state_nxt   = S_SCAN;
        end
      end

      // one pass over nodes 0..next-1 keeps the two smallest keys
      S_SCAN: begin
        if (idx_r != next_r) begin
          scan_v_nxt   = 1'b1;
          scan_idx_nxt = idx_r;
          idx_nxt      = idx_r + 1'b1;
        end else begin
          scan_v_nxt = 1'b0;
        end
        if (scan_v_r && nrsp.live) begin
          if (!best_v_r || (x_key < best_key_r)) begin
            sec_key_nxt  = best_key_r;
            sec_v_nxt    = best_v_r;
            best_key_nxt = x_key;
            best_v_nxt   = 1'b1;
          end else if (!sec_v_r || (x_key < sec_key_r)) begin
            sec_key_nxt = x_key;
            sec_v_nxt   = 1'b1;
          end
        end
        if (scan_done) begin
          // idx_r equals next_r here: write the merged node
          nreq.we_data = 1'b1;
          nreq.we_kids = 1'b1;
          nreq.we_live = 1'b1;
          nreq.live    = 1'b1;
          nreq.data    = INFO_W'(wsat);
          nreq.kids    = {best_key_r.idx, sec_key_r.idx};
          next_nxt    = next_r + 1'b1;
          merge_k_nxt = merge_k_r + 1'b1;
          if ((merge_k_r + NODE_W'(2)) == n_r) begin
            root_nxt  = next_r;
            idx_nxt   = next_r;
            state_nxt = S_T_RD;
          end else begin
            state_nxt = S_KILL0;
          end
        end
      end

      // retire the two merged nodes, then rescan
      S_KILL0: begin
        nreq.addr    = best_key_r.idx;
        nreq.we_live = 1'b1;
        state_nxt    = S_KILL1;
      end

      S_KILL1: begin
        nreq.addr    = sec_key_r.idx;
        nreq.we_live = 1'b1;
        idx_nxt      = '0;
        best_v_nxt   = 1'b0;
        sec_v_nxt    = 1'b0;
        state_nxt    = S_SCAN;
      end

      // top-down code assignment, parents always above their children
      S_T_RD: begin
        state_nxt = S_T_W0;
      end

      S_T_W0, S_T_W1: begin
        if (ch_node < SYMBOLS) begin
          sreq.addr = ch_node[SYM_W-1:0];
          if (ch_depth <= MAX_CODE_LEN) begin
            sreq.code_we   = 1'b1;
            sreq.code_len  = ch_depth;
            sreq.code_bits = ch_code;
          end
        end else begin
          nreq.addr    = ch_node;
          nreq.we_data = 1'b1;
          nreq.data    = {ch_depth, ch_code};
        end
        if (state_r == S_T_W0) begin
          t_node_nxt  = nrsp.kids[NODE_W-1:0];
          t_depth_nxt = kid_depth;
          t_code_nxt  = {par_code[MAX_CODE_LEN-2:0], 1'b1};
          state_nxt   = S_T_W1;
        end else if (idx_r == NODE_W'(SYMBOLS)) begin
          tbl_rdy_nxt  = 1'b1;
          res_stat_nxt = ST_OK;
          state_nxt    = S_RESULT;
        end else begin
          idx_nxt   = idx_r - 1'b1;
          state_nxt = S_T_RD;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      idx_r       <= '0;
      acc_r       <= '0;
      fill_r      <= '0;
      total_r     <= '0;
      tbl_rdy_r   <= 1'b0;
      best_v_r    <= 1'b0;
      sec_v_r     <= 1'b0;
      scan_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      acc_r       <= acc_nxt;
      fill_r      <= fill_nxt;
      total_r     <= total_nxt;
      tbl_rdy_r   <= tbl_rdy_nxt;
      best_v_r    <= best_v_nxt;
      sec_v_r     <= sec_v_nxt;
      scan_v_r    <= scan_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    byte_r      <= byte_nxt;
    res_stat_r  <= res_stat_nxt;
    n_r         <= n_nxt;
    lone_r      <= lone_nxt;
    next_r      <= next_nxt;
    merge_k_r   <= merge_k_nxt;
    root_r      <= root_nxt;
    best_key_r  <= best_key_nxt;
    sec_key_r   <= sec_key_nxt;
    scan_idx_r  <= scan_idx_nxt;
    pend_r      <= pend_nxt;
    pend_cnt_r  <= pend_cnt_nxt;
    t_node_r    <= t_node_nxt;
    t_depth_r   <= t_depth_nxt;
    t_code_r    <= t_code_nxt;
    out_byte_r  <= out_byte_nxt;
    out_last_r  <= out_last_nxt;
    out_stat_r  <= out_stat_nxt;
    out_total_r <= out_total_nxt;
  end

  `HBE_CHECK_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "word taken while busy")
  `HBE_CHECK(a_emit_full, state_r == S_EMIT, pend_cnt_r >= LEN_W'(BYTE_W), "emit short")
  `HBE_CHECK(a_merge_pair, scan_done, pair_ok, "bad merge pair")
  `HBE_CHECK(a_no_table_in_build, state_r == S_SCAN || state_r == S_T_RD, !tbl_rdy_r, "table live mid-build")

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the static Huffman build-and-encode core.
// Depends on hbe_pkg and huffman_build_and_encode_core; runs on its own.
`timescale 1ns / 1ps

module tb_top;
  import hbe_pkg::*;

  localparam int WATCHDOG_LIMIT = 400000;  // covers a full 256-symbol build
  localparam int QUIET_AFTER    = 270;     // random words after which idling stops

  typedef struct packed {
    logic [7:0]  byte_val;
    logic        last;
    logic [1:0]  status;
    logic [38:0] total;
  } code_word_t;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  byte_val;
    bit          typed;      // expected word written out in the row
    code_word_t  word;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_kind = KIND_COUNT;
  logic [7:0]  in_byte = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        out_last_of_run;
  logic [1:0]  out_status;
  logic [38:0] out_total_bits;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  huffman_build_and_encode_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind), .in_byte(in_byte),
    .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
    .out_last_of_run(out_last_of_run), .out_status(out_status),
    .out_total_bits(out_total_bits)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the encoder: histogram, code table, bit packer
  // ---------------------------------------------------------------------------
  logic [31:0] hist [0:255];
  logic [31:0] nw [0:510];         // node weights during a build
  bit          live [0:510];
  int          parent [0:510];
  bit          side [0:510];
  logic [63:0] code_val [0:255];
  int          code_len [0:255];
  bit          tbl_ready;
  logic [7:0]  pk_acc;
  int          pk_fill;
  logic [37:0] bit_total;

  code_word_t exp_words [$];       // words still owed by the core
  code_word_t fresh_words [$];     // words caused by the item just accepted

  int errors = 0;
  int n_items = 0;
  int n_words = 0;
  int n_builds = 0;
  int n_rand = 0;
  bit quiet = 1'b0;

  // merge order: lighter first, then smaller symbol (internal = 0), then older node
  function automatic bit node_first(int a, int b);
    int sa, sb;
    sa = (a < 256) ? a : 0;
    sb = (b < 256) ? b : 0;
    if (nw[a] != nw[b]) return nw[a] < nw[b];
    if (sa != sb) return sa < sb;
    return a < b;
  endfunction

  function automatic int lightest(int limit);
    int best;
    best = -1;
    for (int i = 0; i < limit; i++)
      if (live[i] && (best < 0 || node_first(i, best))) best = i;
    return best;
  endfunction

  function automatic logic [1:0] build_codes();
    int n, nxt, a, b, x, d, root;
    logic [32:0] w;
    logic [63:0] code;
    n = 0;
    for (int i = 0; i < 511; i++) begin
      live[i] = 1'b0;
      parent[i] = 0;
      side[i] = 1'b0;
    end
    for (int s = 0; s < 256; s++) code_len[s] = 0;
    tbl_ready = 1'b0;
    for (int s = 0; s < 256; s++) begin
      if (hist[s] != 0) begin
        nw[s] = hist[s];
        live[s] = 1'b1;
        n++;
      end
    end
    if (n == 0) return ST_EMPTY;
    if (n == 1) begin
      // lone symbol: one-bit code 0
      for (int s = 0; s < 256; s++)
        if (live[s]) begin
          code_val[s] = '0;
          code_len[s] = 1;
        end
      tbl_ready = 1'b1;
      return ST_OK;
    end
    nxt = 256;
    for (int k = 0; k < n - 1; k++) begin
      a = lightest(nxt);
      live[a] = 1'b0;
      b = lightest(nxt);
      live[b] = 1'b0;
      w = {1'b0, nw[a]} + {1'b0, nw[b]};
      nw[nxt] = w[32] ? 32'hFFFF_FFFF : w[31:0];
      parent[a] = nxt;
      parent[b] = nxt;
      side[a] = 1'b0;
      side[b] = 1'b1;
      live[nxt] = 1'b1;
      nxt++;
    end
    root = nxt - 1;
    for (int s = 0; s < 256; s++) begin
      if (hist[s] == 0) continue;
      d = 0;
      code = '0;
      x = s;
      while (x != root) begin
        if (d < 64) code[d] = side[x];
        d++;
        x = parent[x];
      end
      if (d <= MAX_CODE_LEN) begin
        code_val[s] = code;
        code_len[s] = d;
      end
    end
    tbl_ready = 1'b1;
    return ST_OK;
  endfunction

  function automatic code_word_t mk_word(logic [7:0] bv, logic [1:0] st);
    code_word_t r;
    r.byte_val = bv;
    r.last = 1'b0;
    r.status = st;
    r.total = {1'b0, bit_total};
    return r;
  endfunction

  // advances the shadow by one word and leaves its results in fresh_words
  task automatic huff_predict(logic [1:0] kind, logic [7:0] bv);
    logic [7:0] acc;
    int fill, len;
    logic [38:0] sum;
    fresh_words.delete();
    case (kind)
      KIND_COUNT: begin
        if (hist[bv] != 32'hFFFF_FFFF) hist[bv] = hist[bv] + 1;
      end
      KIND_BUILD: begin
        fresh_words = {fresh_words, mk_word(8'd0, build_codes())};
        n_builds++;
      end
      KIND_ENCODE: begin
        if (!tbl_ready) fresh_words = {fresh_words, mk_word(8'd0, ST_NOT_BUILT)};
        else if (code_len[bv] == 0) fresh_words = {fresh_words, mk_word(8'd0, ST_NO_CODE)};
        else begin
          len = code_len[bv];
          acc = pk_acc;
          fill = pk_fill;
          for (int i = len; i > 0; i--) begin
            acc = {acc[6:0], code_val[bv][i-1]};
            fill++;
            if (fill == 8) begin
              fresh_words = {fresh_words, mk_word(acc, ST_OK)};
              acc = '0;
              fill = 0;
            end
          end
          pk_acc = {1'b0, acc[6:0]};
          pk_fill = fill;
          sum = {1'b0, bit_total} + len;
          bit_total = sum[38] ? '1 : sum[37:0];
          foreach (fresh_words[i]) fresh_words[i].total = {1'b0, bit_total};
        end
      end
      default: begin
        // flush: pad the partial byte, then start a new message
        fresh_words = {fresh_words,
                       mk_word((pk_fill > 0) ? (pk_acc << (8 - pk_fill)) : 8'd0, ST_OK)};
        for (int s = 0; s < 256; s++) begin
          hist[s] = '0;
          code_len[s] = 0;
        end
        tbl_ready = 1'b0;
        pk_acc = '0;
        pk_fill = 0;
        bit_total = '0;
      end
    endcase
    if (fresh_words.size() > 0) fresh_words[fresh_words.size()-1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  // Presents one word and holds it until taken; the shadow advances on accept.
  // A typed row replaces the shadow's answer with the one written in the table.
  task automatic send_word(logic [1:0] kind, logic [7:0] bv, bit typed = 1'b0,
                           code_word_t tw = '0);
    int gap;
    in_valid <= 1'b1;
    in_kind <= kind;
    in_byte <= bv;
    do @(posedge clk); while (!in_ready);
    n_items++;
    huff_predict(kind, bv);
    if (typed) exp_words = {exp_words, tw};
    else foreach (fresh_words[i]) exp_words = {exp_words, fresh_words[i]};
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off until the core has delivered everything it owes
  task automatic drain_words();
    in_valid <= 1'b0;
    @(posedge clk);
    while (exp_words.size() != 0) @(posedge clk);
  endtask

  function automatic code_word_t tw(logic [7:0] bv, logic [1:0] st, logic [38:0] tot);
    code_word_t r;
    r.byte_val = bv;
    r.last = 1'b1;
    r.status = st;
    r.total = tot;
    return r;
  endfunction

  row_t rows [$];

  task automatic add_row(logic [1:0] kind, logic [7:0] bv, bit typed = 1'b0,
                         code_word_t w = '0);
    row_t r;
    r.kind = kind;
    r.byte_val = bv;
    r.typed = typed;
    r.word = w;
    rows = {rows, r};
  endtask

  // one message: count, build, encode, flush; some are broken on purpose
  task automatic random_message(int msg_idx);
    logic [7:0] alph [$];
    int k, ncount, nenc, shape, pick;
    logic [7:0] sym;
    alph.delete();
    k = (msg_idx == 5) ? 60 : (($urandom_range(0, 3) == 0) ? $urandom_range(9, 20)
                                                           : $urandom_range(1, 8));
    for (int i = 0; i < k; i++) alph = {alph, 8'($urandom_range(0, 255))};
    ncount = (msg_idx == 5) ? 70 : $urandom_range(k, k + 12);
    nenc = $urandom_range(3, 14);
    shape = $urandom_range(0, 9);  // 0: skip build, 1: skip flush, 2: noise mix
    if (shape == 0 && $urandom_range(0, 1)) begin
      send_word(KIND_ENCODE, alph[0]);
      n_rand++;
    end
    for (int i = 0; i < ncount; i++) begin
      // skewed pick gives uneven weights and deeper trees
      pick = $urandom_range(0, $urandom_range(0, k - 1));
      sym = (i < k) ? alph[i] : alph[pick];
      send_word(KIND_COUNT, sym);
      n_rand++;
      if (shape == 2 && $urandom_range(0, 4) == 0) begin
        send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        n_rand++;
      end
    end
    if (shape != 0) begin
      send_word(KIND_BUILD, 8'($urandom_range(0, 255)));
      n_rand++;
    end
    for (int i = 0; i < nenc; i++) begin
      sym = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255))
                                        : alph[$urandom_range(0, k - 1)];
      send_word(($urandom_range(0, 15) == 0) ? KIND_COUNT : KIND_ENCODE, sym);
      n_rand++;
    end
    if (shape != 1) begin
      if (msg_idx == 2 || $urandom_range(0, 3) == 0) drain_words();
      send_word(KIND_FLUSH, 8'($urandom_range(0, 255)));
      n_rand++;
    end
    if (n_rand > QUIET_AFTER) quiet = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int msg;
    for (int s = 0; s < 256; s++) begin
      hist[s] = '0;
      code_len[s] = 0;
      code_val[s] = '0;
    end
    tbl_ready = 1'b0;
    pk_acc = '0;
    pk_fill = 0;
    bit_total = '0;

    // empty state: encode before build, empty build, flush with nothing pending
    add_row(KIND_ENCODE, 8'd7,   1'b1, tw(8'd0, ST_NOT_BUILT, 39'd0));
    add_row(KIND_BUILD,  8'd0,   1'b1, tw(8'd0, ST_EMPTY, 39'd0));
    add_row(KIND_ENCODE, 8'd0,   1'b1, tw(8'd0, ST_NOT_BUILT, 39'd0));
    add_row(KIND_FLUSH,  8'd0,   1'b1, tw(8'd0, ST_OK, 39'd0));
    // lone symbol at the top byte value: code 0, one bit
    add_row(KIND_COUNT,  8'd255);
    add_row(KIND_BUILD,  8'd0,   1'b1, tw(8'd0, ST_OK, 39'd0));
    add_row(KIND_ENCODE, 8'd255);
    add_row(KIND_ENCODE, 8'd0,   1'b1, tw(8'd0, ST_NO_CODE, 39'd1));
    add_row(KIND_FLUSH,  8'hFF,  1'b1, tw(8'd0, ST_OK, 39'd1));
    // three symbols with a weight tie, count after build, byte completion
    add_row(KIND_COUNT,  8'd0);
    add_row(KIND_COUNT,  8'd0);
    add_row(KIND_COUNT,  8'd255);
    add_row(KIND_COUNT,  8'd128);
    add_row(KIND_BUILD,  8'd0);
    add_row(KIND_COUNT,  8'd77);
    add_row(KIND_ENCODE, 8'd77);
    for (int i = 0; i < 6; i++) add_row(KIND_ENCODE, (i % 2) ? 8'd255 : 8'd128);
    add_row(KIND_ENCODE, 8'd0);
    add_row(KIND_FLUSH,  8'd0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_word(rows[i].kind, rows[i].byte_val, rows[i].typed, rows[i].word);

    msg = 0;
    while (n_rand < 330) begin
      random_message(msg);
      msg++;
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (exp_words.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Covered %0d input words over %0d messages, %0d builds, %0d code words checked.",
             n_items, msg, n_builds, n_words);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, in-order compare against the oldest expectation
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  always @(posedge clk) begin
    code_word_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        n_words++;
        if (exp_words.size() == 0) begin
          $display("%0t unexpected word: byte %h status %0d total %0d", $time,
                   out_byte, out_status, out_total_bits);
          errors++;
        end else begin
          e = exp_words.pop_front();
          if (out_byte !== e.byte_val) begin
            $display("%0t out_byte exp %h got %h", $time, e.byte_val, out_byte);
            errors++;
          end
          if (out_last_of_run !== e.last) begin
            $display("%0t out_last_of_run exp %b got %b", $time, e.last, out_last_of_run);
            errors++;
          end
          if (out_status !== e.status) begin
            $display("%0t out_status exp %0d got %0d", $time, e.status, out_status);
            errors++;
          end
          if (out_total_bits !== e.total) begin
            $display("%0t out_total_bits exp %0d got %0d", $time, e.total, out_total_bits);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        stall_left <= $urandom_range(0, 3);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog: cycles with no word moving on either channel
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no handshake for %0d cycles, %0d words owed", $time,
               idle_cycles, exp_words.size());
      $display("Regression FAIL");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/hbe_pkg.sv
sv/hbe_sym_mem.sv
sv/hbe_node_mem.sv
sv/huffman_build_and_encode_core.sv
tb/tb_top.sv
